// File: sv/nwp_pkg.sv
package nwp_pkg;

    // Field and datapath widths
    localparam int COORD_W      = 20;   // Q11.8 vertex coordinate
    localparam int MAX_VERTICES = 256;
    localparam int CNT_W        = 9;    // holds 0..MAX_VERTICES
    localparam int NSUM_W       = 51;   // Newell sum, signed
    localparam int CSUM_W       = 29;   // coordinate sum, signed
    localparam int MUL_W        = 32;   // shared multiplier operand width
    localparam int PROD_W       = 62;   // registered product width
    localparam int ACC_W        = 63;   // sum of squares / dot accumulator
    localparam int MAG_W        = 30;   // normalized magnitude width
    localparam int SQ_W         = 62;   // square-root working width
    localparam int SQRT_STEPS   = 31;
    localparam int NUM_W        = 45;   // divider numerator width
    localparam int DEN_W        = 31;   // divider denominator width
    localparam int DIV_STEPS    = NUM_W;
    localparam int NRM_FRAC     = 14;   // Q1.14 normal
    localparam int NRM_W        = 16;
    localparam int NRMI_W       = 17;   // internal normal, holds +/-16384
    localparam int DOT_W        = 40;
    localparam int DIST_W       = 21;
    localparam int RND_W        = DOT_W - NRM_FRAC;
    localparam int MIN_VERTICES = 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE,
        ST_CLOSE,
        ST_MAG,
        ST_CDIV,
        ST_CHK,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_NDIV,
        ST_DOT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        MUL_EDGE,
        MUL_SQ,
        MUL_DOT
    } t_mul_op;

    typedef enum logic {
        DIV_CENTER,
        DIV_NORMAL
    } t_div_sel;

    typedef struct packed {
        logic       in_ready;
        t_mul_op    mul_op;
        logic       edge_close;
        logic [1:0] mul_idx;
        logic       acc_nsum;
        logic       acc_sum;
        logic [1:0] acc_idx;
        logic       upd;
        logic       mag_load;
        logic       norm_step;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_start;
        logic       div_store;
        t_div_sel   div_sel;
        logic [1:0] div_idx;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic last;
        logic norm_ok;
        logic plane_ok;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// File: sv/nwp_div.sv
// Restoring unsigned divider, one quotient bit per cycle
module nwp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nwp_pkg::NUM_W-1:0]   i_num,
    input  logic [nwp_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [nwp_pkg::NUM_W-1:0]   o_quot
);

    localparam int STEP_W = $clog2(nwp_pkg::DIV_STEPS);

    logic                       r_busy;
    logic [STEP_W-1:0]          r_step;
    logic [nwp_pkg::NUM_W-1:0]  r_q;
    logic [nwp_pkg::DEN_W-1:0]  r_rem;
    logic [nwp_pkg::DEN_W-1:0]  r_den;
    logic [nwp_pkg::DEN_W:0]    shifted;
    logic                       fits;

    // trial subtract of the shifted partial remainder
    assign shifted = {r_rem, r_q[nwp_pkg::NUM_W-1]};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(nwp_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q <= {r_q[nwp_pkg::NUM_W-2:0], fits};
            if (fits) begin
                r_rem <= nwp_pkg::DEN_W'(shifted - {1'b0, r_den});
            end else begin
                r_rem <= shifted[nwp_pkg::DEN_W-1:0];
            end
        end
    end

    assign o_done = !r_busy;
    assign o_quot = r_q;

endmodule

// File: sv/nwp_ctrl.sv
// Sequencer: walks the datapath through vertex edges and the final plane solve
module nwp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  nwp_pkg::t_status i_status,
    output nwp_pkg::t_cmd    o_cmd
);

    localparam int CNT_SW = $clog2(nwp_pkg::SQRT_STEPS + 1);

    nwp_pkg::t_state   r_state, n_state;
    logic [1:0]        r_k, n_k;
    logic [1:0]        r_j, n_j;
    logic [CNT_SW-1:0] r_cnt, n_cnt;
    logic              r_phase, n_phase;
    logic              edge_fin;
    logic [1:0]        k_mul;

    // vertex done: skipped, first of polygon, or last edge product accumulated
    assign edge_fin = i_status.cnt_full || i_status.cnt_zero || (r_k == 2'd3);
    assign k_mul    = (r_k == 2'd3) ? 2'd0 : r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nwp_pkg::ST_IDLE;
            r_k     <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_j     <= n_j;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
        end
    end

    // next state and step counters
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_j     = r_j;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        case (r_state)
            nwp_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = nwp_pkg::ST_EDGE;
                    n_k     = '0;
                end
            end
            nwp_pkg::ST_EDGE: begin
                if (edge_fin) begin
                    n_k = '0;
                    if (i_status.last) begin
                        n_state = nwp_pkg::ST_CLOSE;
                    end else if (i_valid) begin
                        n_state = nwp_pkg::ST_EDGE;
                    end else begin
                        n_state = nwp_pkg::ST_IDLE;
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            nwp_pkg::ST_CLOSE: begin
                if (r_k == 2'd3) begin
                    n_state = nwp_pkg::ST_MAG;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            nwp_pkg::ST_MAG: begin
                n_state = nwp_pkg::ST_CDIV;
                n_j     = '0;
                n_phase = 1'b0;
            end
            nwp_pkg::ST_CDIV, nwp_pkg::ST_NDIV: begin
                if (!r_phase) begin
                    n_phase = 1'b1;
                end else if (i_status.div_done) begin
                    n_phase = 1'b0;
                    if (r_j == 2'd2) begin
                        n_j = '0;
                        n_k = '0;
                        n_state = (r_state == nwp_pkg::ST_CDIV) ? nwp_pkg::ST_CHK
                                                                 : nwp_pkg::ST_DOT;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            nwp_pkg::ST_CHK: begin
                n_state = i_status.plane_ok ? nwp_pkg::ST_NORM : nwp_pkg::ST_OUT;
            end
            nwp_pkg::ST_NORM: begin
                if (i_status.norm_ok) begin
                    n_state = nwp_pkg::ST_SQ;
                    n_k     = '0;
                end
            end
            nwp_pkg::ST_SQ: begin
                if (r_k == 2'd3) begin
                    n_state = nwp_pkg::ST_SQRT;
                    n_cnt   = '0;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            nwp_pkg::ST_SQRT: begin
                if (r_cnt == CNT_SW'(nwp_pkg::SQRT_STEPS)) begin
                    n_state = nwp_pkg::ST_NDIV;
                    n_j     = '0;
                    n_phase = 1'b0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            nwp_pkg::ST_DOT: begin
                if (r_k == 2'd3) begin
                    n_state = nwp_pkg::ST_OUT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            nwp_pkg::ST_OUT: begin
                if (i_status.out_free) begin
                    n_state = nwp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nwp_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_op   = nwp_pkg::MUL_EDGE;
        o_cmd.div_sel  = nwp_pkg::DIV_CENTER;
        o_cmd.mul_idx  = k_mul;
        o_cmd.acc_idx  = r_k - 2'd1;
        o_cmd.div_idx  = r_j;
        case (r_state)
            nwp_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
            end
            nwp_pkg::ST_EDGE: begin
                o_cmd.acc_nsum = !i_status.cnt_full && !i_status.cnt_zero && (r_k != 2'd0);
                o_cmd.upd      = !i_status.cnt_full && edge_fin;
                o_cmd.in_ready = edge_fin && !i_status.last;
            end
            nwp_pkg::ST_CLOSE: begin
                o_cmd.edge_close = 1'b1;
                o_cmd.acc_nsum   = (r_k != 2'd0);
            end
            nwp_pkg::ST_MAG: begin
                o_cmd.mag_load = 1'b1;
            end
            nwp_pkg::ST_CDIV: begin
                o_cmd.div_start = !r_phase;
                o_cmd.div_store = r_phase && i_status.div_done;
            end
            nwp_pkg::ST_NDIV: begin
                o_cmd.div_sel   = nwp_pkg::DIV_NORMAL;
                o_cmd.div_start = !r_phase;
                o_cmd.div_store = r_phase && i_status.div_done;
            end
            nwp_pkg::ST_NORM: begin
                o_cmd.norm_step = !i_status.norm_ok;
            end
            nwp_pkg::ST_SQ: begin
                o_cmd.mul_op  = nwp_pkg::MUL_SQ;
                o_cmd.acc_sum = (r_k != 2'd0);
            end
            nwp_pkg::ST_SQRT: begin
                o_cmd.sqrt_init = (r_cnt == '0);
                o_cmd.sqrt_step = (r_cnt != '0);
            end
            nwp_pkg::ST_DOT: begin
                o_cmd.mul_op  = nwp_pkg::MUL_DOT;
                o_cmd.acc_sum = (r_k != 2'd0);
            end
            nwp_pkg::ST_OUT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd.in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/nwp_dpath.sv
// Datapath: vertex store, Newell sums, shared multiplier, sqrt, divider, result register
module nwp_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  nwp_pkg::t_cmd                      i_cmd,
    input  logic                               i_valid,
    input  logic signed [nwp_pkg::COORD_W-1:0] i_vertex_x,
    input  logic signed [nwp_pkg::COORD_W-1:0] i_vertex_y,
    input  logic signed [nwp_pkg::COORD_W-1:0] i_vertex_z,
    input  logic                               i_last_vertex,
    input  logic                               i_stall,
    output nwp_pkg::t_status                   o_status,
    output logic                               o_valid,
    output logic signed [nwp_pkg::NRM_W-1:0]   o_normal_x,
    output logic signed [nwp_pkg::NRM_W-1:0]   o_normal_y,
    output logic signed [nwp_pkg::NRM_W-1:0]   o_normal_z,
    output logic signed [nwp_pkg::COORD_W-1:0] o_center_x,
    output logic signed [nwp_pkg::COORD_W-1:0] o_center_y,
    output logic signed [nwp_pkg::COORD_W-1:0] o_center_z,
    output logic signed [nwp_pkg::DIST_W-1:0]  o_plane_distance,
    output logic [nwp_pkg::CNT_W-1:0]          o_vertex_count,
    output logic                               o_plane_valid
);

    localparam int CW = nwp_pkg::COORD_W;
    localparam logic [nwp_pkg::SQ_W-1:0] SQRT_BIT0 =
        nwp_pkg::SQ_W'(1) << (2 * (nwp_pkg::SQRT_STEPS - 1));
    localparam logic [nwp_pkg::RND_W-1:0] DIST_POS_MAX =
        nwp_pkg::RND_W'((1 << (nwp_pkg::DIST_W - 1)) - 1);
    localparam logic [nwp_pkg::RND_W-1:0] DIST_NEG_MAX =
        nwp_pkg::RND_W'(1 << (nwp_pkg::DIST_W - 1));

    // working state
    logic signed [CW-1:0]                   r_vin   [3];
    logic signed [CW-1:0]                   r_first [3];
    logic signed [CW-1:0]                   r_prev  [3];
    logic                                   r_last;
    logic signed [nwp_pkg::NSUM_W-1:0]      r_nsum  [3];
    logic signed [nwp_pkg::CSUM_W-1:0]      r_csum  [3];
    logic [nwp_pkg::CNT_W-1:0]              r_count;
    logic signed [nwp_pkg::PROD_W-1:0]      r_prod;
    logic signed [nwp_pkg::ACC_W-1:0]       r_acc;
    logic [nwp_pkg::NSUM_W-1:0]             r_mag   [3];
    logic                                   r_neg   [3];
    logic signed [CW-1:0]                   r_center[3];
    logic signed [nwp_pkg::NRMI_W-1:0]      r_nrm   [3];
    logic [nwp_pkg::SQ_W-1:0]               r_rem;
    logic [nwp_pkg::SQ_W-1:0]               r_res;
    logic [nwp_pkg::SQ_W-1:0]               r_bit;

    // result register
    logic                                   r_ovalid;
    logic signed [nwp_pkg::NRM_W-1:0]       r_o_nrm [3];
    logic signed [CW-1:0]                   r_o_cen [3];
    logic signed [nwp_pkg::DIST_W-1:0]      r_o_dist;
    logic [nwp_pkg::CNT_W-1:0]              r_o_cnt;
    logic                                   r_o_pvalid;

    logic                                   accept;
    logic [1:0]                             iu, iw;
    logic signed [CW-1:0]                   ea_u, eb_u, ea_w, eb_w;
    logic signed [CW:0]                     e_diff, e_sum;
    logic signed [nwp_pkg::MUL_W-1:0]       mul_a, mul_b;
    logic signed [2*nwp_pkg::MUL_W-1:0]     prod_full;
    logic [nwp_pkg::NSUM_W-1:0]             big01, big;
    logic                                   norm_hi, norm_lo, plane_ok;
    logic [nwp_pkg::SQ_W-1:0]               sq_try;
    logic [nwp_pkg::DEN_W-1:0]              len;
    logic [nwp_pkg::CSUM_W-1:0]             cen_mag;
    logic [nwp_pkg::NUM_W-1:0]              div_num;
    logic [nwp_pkg::DEN_W-1:0]              div_den;
    logic                                   div_done;
    logic [nwp_pkg::NUM_W-1:0]              div_quot;
    logic signed [CW-1:0]                   q_center;
    logic signed [nwp_pkg::NRMI_W-1:0]      q_nrm;
    logic signed [nwp_pkg::DOT_W-1:0]       dot;
    logic                                   dot_neg;
    logic [nwp_pkg::DOT_W-1:0]              dot_mag;
    logic [nwp_pkg::RND_W-1:0]              dot_rnd;
    logic signed [nwp_pkg::DIST_W-1:0]      dist_sat;
    logic                                   out_free;

    assign accept   = i_valid && i_cmd.in_ready;
    assign out_free = !r_ovalid || !i_stall;

    // input capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= 1'b0;
        end else if (accept) begin
            r_last <= i_last_vertex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vin[0] <= i_vertex_x;
            r_vin[1] <= i_vertex_y;
            r_vin[2] <= i_vertex_z;
        end
    end

    // edge operands: component k uses the two coordinates after it
    always_comb begin
        case (i_cmd.mul_idx)
            2'd0:    begin iu = 2'd1; iw = 2'd2; end
            2'd1:    begin iu = 2'd2; iw = 2'd0; end
            default: begin iu = 2'd0; iw = 2'd1; end
        endcase
        ea_u = r_prev[iu];
        ea_w = r_prev[iw];
        eb_u = i_cmd.edge_close ? r_first[iu] : r_vin[iu];
        eb_w = i_cmd.edge_close ? r_first[iw] : r_vin[iw];
        e_diff = (CW+1)'(ea_u) - (CW+1)'(eb_u);
        e_sum  = (CW+1)'(ea_w) + (CW+1)'(eb_w);
    end

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_op)
            nwp_pkg::MUL_EDGE: begin
                mul_a = nwp_pkg::MUL_W'(e_diff);
                mul_b = nwp_pkg::MUL_W'(e_sum);
            end
            nwp_pkg::MUL_SQ: begin
                mul_a = $signed({2'b00, r_mag[i_cmd.mul_idx][nwp_pkg::MAG_W-1:0]});
                mul_b = $signed({2'b00, r_mag[i_cmd.mul_idx][nwp_pkg::MAG_W-1:0]});
            end
            nwp_pkg::MUL_DOT: begin
                mul_a = nwp_pkg::MUL_W'(r_center[i_cmd.mul_idx]);
                mul_b = nwp_pkg::MUL_W'(r_nrm[i_cmd.mul_idx]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        r_prod <= prod_full[nwp_pkg::PROD_W-1:0];
    end

    // Newell sums, coordinate sums, vertex count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int i = 0; i < 3; i++) begin
                r_nsum[i] <= '0;
                r_csum[i] <= '0;
            end
        end else if (i_cmd.out_load) begin
            r_count <= '0;
            for (int i = 0; i < 3; i++) begin
                r_nsum[i] <= '0;
                r_csum[i] <= '0;
            end
        end else begin
            if (i_cmd.acc_nsum) begin
                r_nsum[i_cmd.acc_idx] <= r_nsum[i_cmd.acc_idx]
                                         + nwp_pkg::NSUM_W'(r_prod);
            end
            if (i_cmd.upd) begin
                r_count <= r_count + 1'b1;
                for (int i = 0; i < 3; i++) begin
                    r_csum[i] <= r_csum[i] + nwp_pkg::CSUM_W'(r_vin[i]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            for (int i = 0; i < 3; i++) begin
                r_prev[i] <= r_vin[i];
                if (r_count == '0) begin
                    r_first[i] <= r_vin[i];
                end
            end
        end
    end

    // largest magnitude and its range against [2^29, 2^30)
    assign big01    = (r_mag[0] > r_mag[1]) ? r_mag[0] : r_mag[1];
    assign big      = (big01 > r_mag[2]) ? big01 : r_mag[2];
    assign norm_hi  = |big[nwp_pkg::NSUM_W-1:nwp_pkg::MAG_W];
    assign norm_lo  = ~|big[nwp_pkg::NSUM_W-1:nwp_pkg::MAG_W-1];
    assign plane_ok = (r_count >= nwp_pkg::CNT_W'(nwp_pkg::MIN_VERTICES)) && (big != '0);

    // magnitudes, normalize shifts, normal results
    always_ff @(posedge i_clk) begin
        if (i_cmd.mag_load) begin
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= r_nsum[i][nwp_pkg::NSUM_W-1];
                r_mag[i] <= r_nsum[i][nwp_pkg::NSUM_W-1] ? nwp_pkg::NSUM_W'(-r_nsum[i])
                                                          : nwp_pkg::NSUM_W'(r_nsum[i]);
                r_nrm[i] <= '0;
            end
        end else if (i_cmd.norm_step) begin
            for (int i = 0; i < 3; i++) begin
                if (norm_hi) begin
                    r_mag[i] <= r_mag[i] >> 1;
                end else begin
                    r_mag[i] <= r_mag[i] << 1;
                end
            end
        end else if (i_cmd.div_store && i_cmd.div_sel == nwp_pkg::DIV_NORMAL) begin
            r_nrm[i_cmd.div_idx] <= q_nrm;
        end
    end

    // sum of squares and dot product accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.mag_load) begin
            r_acc <= '0;
        end else if (i_cmd.acc_sum) begin
            r_acc <= ((i_cmd.acc_idx == 2'd0) ? '0 : r_acc) + nwp_pkg::ACC_W'(r_prod);
        end
    end

    // bitwise integer square root, two bits of radicand per step
    assign sq_try = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_rem <= r_acc[nwp_pkg::SQ_W-1:0];
            r_res <= '0;
            r_bit <= SQRT_BIT0;
        end else if (i_cmd.sqrt_step) begin
            if (r_rem >= sq_try) begin
                r_rem <= r_rem - sq_try;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign len = r_res[nwp_pkg::DEN_W-1:0];

    // divider operands: rounded centroid or rounded normal component
    always_comb begin
        cen_mag = r_csum[i_cmd.div_idx][nwp_pkg::CSUM_W-1]
                ? nwp_pkg::CSUM_W'(-r_csum[i_cmd.div_idx])
                : nwp_pkg::CSUM_W'(r_csum[i_cmd.div_idx]);
        case (i_cmd.div_sel)
            nwp_pkg::DIV_CENTER: begin
                div_num = nwp_pkg::NUM_W'(cen_mag) + nwp_pkg::NUM_W'(r_count >> 1);
                div_den = nwp_pkg::DEN_W'(r_count);
            end
            nwp_pkg::DIV_NORMAL: begin
                div_num = nwp_pkg::NUM_W'({r_mag[i_cmd.div_idx][nwp_pkg::MAG_W-1:0],
                                           {nwp_pkg::NRM_FRAC{1'b0}}})
                        + nwp_pkg::NUM_W'(len >> 1);
                div_den = len;
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
        q_center = r_csum[i_cmd.div_idx][nwp_pkg::CSUM_W-1] ? -$signed(div_quot[CW-1:0])
                                                             : $signed(div_quot[CW-1:0]);
        q_nrm = r_neg[i_cmd.div_idx]
              ? -$signed({2'b00, div_quot[nwp_pkg::NRMI_W-3:0]})
              :  $signed({2'b00, div_quot[nwp_pkg::NRMI_W-3:0]});
    end

    nwp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store && i_cmd.div_sel == nwp_pkg::DIV_CENTER) begin
            r_center[i_cmd.div_idx] <= q_center;
        end
    end

    // plane distance: negate, round half away from zero, saturate
    always_comb begin
        dot     = r_acc[nwp_pkg::DOT_W-1:0];
        dot_neg = dot[nwp_pkg::DOT_W-1];
        dot_mag = dot_neg ? nwp_pkg::DOT_W'(-dot) : nwp_pkg::DOT_W'(dot);
        dot_rnd = nwp_pkg::RND_W'((dot_mag + nwp_pkg::DOT_W'(1 << (nwp_pkg::NRM_FRAC - 1)))
                                  >> nwp_pkg::NRM_FRAC);
        if (dot_neg) begin
            dist_sat = (dot_rnd > DIST_POS_MAX) ? $signed(DIST_POS_MAX[nwp_pkg::DIST_W-1:0])
                                                : $signed(dot_rnd[nwp_pkg::DIST_W-1:0]);
        end else begin
            dist_sat = (dot_rnd > DIST_NEG_MAX) ? -$signed(DIST_NEG_MAX[nwp_pkg::DIST_W-1:0])
                                                : -$signed(dot_rnd[nwp_pkg::DIST_W-1:0]);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int i = 0; i < 3; i++) begin
                r_o_nrm[i] <= r_nrm[i][nwp_pkg::NRM_W-1:0];
                r_o_cen[i] <= r_center[i];
            end
            r_o_dist   <= dist_sat;
            r_o_cnt    <= r_count;
            r_o_pvalid <= plane_ok;
        end
    end

    always_comb begin
        o_status          = '0;
        o_status.cnt_zero = (r_count == '0);
        o_status.cnt_full = (r_count == nwp_pkg::CNT_W'(nwp_pkg::MAX_VERTICES));
        o_status.last     = r_last;
        o_status.norm_ok  = !norm_hi && !norm_lo;
        o_status.plane_ok = plane_ok;
        o_status.div_done = div_done;
        o_status.out_free = out_free;
    end

    assign o_valid          = r_ovalid;
    assign o_normal_x       = r_o_nrm[0];
    assign o_normal_y       = r_o_nrm[1];
    assign o_normal_z       = r_o_nrm[2];
    assign o_center_x       = r_o_cen[0];
    assign o_center_y       = r_o_cen[1];
    assign o_center_z       = r_o_cen[2];
    assign o_plane_distance = r_o_dist;
    assign o_vertex_count   = r_o_cnt;
    assign o_plane_valid    = r_o_pvalid;

endmodule

// File: sv/newell_polygon_plane.sv
// Newell plane of a polygon streamed one vertex per item.
// Input channel: i_valid / o_stall carry one Q11.8 vertex and a last flag.
// Output channel: o_valid / i_stall carry one plane result per polygon:
// unit normal (Q1.14), rounded centroid (Q11.8), plane distance (Q12.8),
// vertex count and a valid flag (at least three vertices, nonzero normal).
// Each vertex runs its edge products, one per normal component, through one shared
// 32x32 multiplier, with the accumulate in the following cycle. The
// first vertex of a polygon adds no edge product. After the flagged vertex
// the solve runs the closing edge, three centroid divisions, the normalize
// shift (one bit a cycle, up to 29), the square root and three normal
// divisions on one serial divider.
// Without a valid plane it ends after the centroid divisions.
// No vertex is taken during the solve.
// Vertices past 256 are dropped; their last flag still closes the polygon.
// Reset (synchronous, active low) clears the Newell and coordinate sums, the vertex count and
// the output valid. The result sits in an output register: while the
// receiver stalls it holds, and the next polygon's vertices are still
// taken until that polygon's own result is ready to load.
module newell_polygon_plane (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [nwp_pkg::COORD_W-1:0] i_vertex_x,
    input  logic signed [nwp_pkg::COORD_W-1:0] i_vertex_y,
    input  logic signed [nwp_pkg::COORD_W-1:0] i_vertex_z,
    input  logic                               i_last_vertex,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [nwp_pkg::NRM_W-1:0]   o_normal_x,
    output logic signed [nwp_pkg::NRM_W-1:0]   o_normal_y,
    output logic signed [nwp_pkg::NRM_W-1:0]   o_normal_z,
    output logic signed [nwp_pkg::COORD_W-1:0] o_center_x,
    output logic signed [nwp_pkg::COORD_W-1:0] o_center_y,
    output logic signed [nwp_pkg::COORD_W-1:0] o_center_z,
    output logic signed [nwp_pkg::DIST_W-1:0]  o_plane_distance,
    output logic [nwp_pkg::CNT_W-1:0]          o_vertex_count,
    output logic                               o_plane_valid
);

    nwp_pkg::t_cmd    cmd;
    nwp_pkg::t_status status;

    assign o_stall = !cmd.in_ready;

    nwp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd)
    );

    nwp_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_valid          (i_valid),
        .i_vertex_x       (i_vertex_x),
        .i_vertex_y       (i_vertex_y),
        .i_vertex_z       (i_vertex_z),
        .i_last_vertex    (i_last_vertex),
        .i_stall          (i_stall),
        .o_status         (status),
        .o_valid          (o_valid),
        .o_normal_x       (o_normal_x),
        .o_normal_y       (o_normal_y),
        .o_normal_z       (o_normal_z),
        .o_center_x       (o_center_x),
        .o_center_y       (o_center_y),
        .o_center_z       (o_center_z),
        .o_plane_distance (o_plane_distance),
        .o_vertex_count   (o_vertex_count),
        .o_plane_valid    (o_plane_valid)
    );

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 12000;
    localparam int LONG_HOLD      = 4000;
    localparam int TAIL_CYCLES    = 500;

    typedef struct {
        logic signed [nwp_pkg::COORD_W-1:0] x, y, z;
        logic                               last;
        bit                                 drain;   // wait for all results before sending
    } t_vertex;

    typedef struct packed {
        logic signed [nwp_pkg::NRM_W-1:0]   nx, ny, nz;
        logic signed [nwp_pkg::COORD_W-1:0] cx, cy, cz;
        logic signed [nwp_pkg::DIST_W-1:0]  pdist;
        logic [nwp_pkg::CNT_W-1:0]          cnt;
        logic                               ok;
    } t_plane;

    logic i_clk, i_rst_n, i_valid, o_stall, i_last_vertex, o_valid, i_stall;
    logic signed [nwp_pkg::COORD_W-1:0] i_vertex_x, i_vertex_y, i_vertex_z;
    logic signed [nwp_pkg::NRM_W-1:0]   o_normal_x, o_normal_y, o_normal_z;
    logic signed [nwp_pkg::COORD_W-1:0] o_center_x, o_center_y, o_center_z;
    logic signed [nwp_pkg::DIST_W-1:0]  o_plane_distance;
    logic [nwp_pkg::CNT_W-1:0]          o_vertex_count;
    logic                               o_plane_valid;

    newell_polygon_plane DUT (.*);

    t_vertex pending_vertices[$];
    t_plane  expected_planes[$];

    // predictor state
    longint first_v[3], prev_v[3], newell_sum[3], coord_sum[3];
    int     seen_count;

    int errors, mismatches, planes_checked, vertices_sent, drains, idle_cycles;
    int burst_left, gap_left, stall_mode_timer, stall_mode, hold_left;
    int valid_planes, overflow_polys;
    bit hold_done;

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    function automatic void add_edge(longint a[3], longint b[3]);
        newell_sum[0] += (a[1] - b[1]) * (a[2] + b[2]);
        newell_sum[1] += (a[2] - b[2]) * (a[0] + b[0]);
        newell_sum[2] += (a[0] - b[0]) * (a[1] + b[1]);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > s) bt >>= 2;
        while (bt != 0) begin
            if (s >= res + bt) begin
                s -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    // Update the polygon state with one accepted vertex; on the last one
    // solve the plane and queue it as the expected result.
    function automatic void plane_accept(t_vertex v);
        longint p[3], ctr[3], nrm[3], dot, dm, dst, q;
        longint unsigned mag[3], big, sq, len;
        bit neg[3];
        t_plane e;
        p[0] = longint'(v.x); p[1] = longint'(v.y); p[2] = longint'(v.z);
        if (seen_count < nwp_pkg::MAX_VERTICES) begin
            if (seen_count == 0) first_v = p;
            else add_edge(prev_v, p);
            for (int i = 0; i < 3; i++) coord_sum[i] += p[i];
            prev_v = p;
            seen_count++;
        end
        if (!v.last) return;
        ctr = '{0, 0, 0};
        nrm = '{0, 0, 0};
        dst = 0;
        e.ok = 1'b0;
        if (seen_count > 0) begin
            add_edge(prev_v, first_v);
            for (int i = 0; i < 3; i++) begin
                dm = coord_sum[i] < 0 ? -coord_sum[i] : coord_sum[i];
                q = (dm + seen_count / 2) / seen_count;
                ctr[i] = coord_sum[i] < 0 ? -q : q;
            end
        end
        big = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = newell_sum[i] < 0;
            mag[i] = neg[i] ? -newell_sum[i] : newell_sum[i];
            if (mag[i] > big) big = mag[i];
        end
        if (seen_count >= 3 && big != 0) begin
            e.ok = 1'b1;
            while (big >= (64'd1 << 30)) begin
                big >>= 1;
                for (int i = 0; i < 3; i++) mag[i] >>= 1;
            end
            while (big < (64'd1 << 29)) begin
                big <<= 1;
                for (int i = 0; i < 3; i++) mag[i] <<= 1;
            end
            sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
            len = int_sqrt(sq);
            for (int i = 0; i < 3; i++) begin
                q = longint'((mag[i] * 16384 + len / 2) / len);
                nrm[i] = neg[i] ? -q : q;
            end
            dot = ctr[0] * nrm[0] + ctr[1] * nrm[1] + ctr[2] * nrm[2];
            dm = dot < 0 ? -dot : dot;
            q = (dm + 8192) >>> 14;
            dst = dot < 0 ? q : -q;
            if (dst > 1048575) dst = 1048575;
            if (dst < -1048576) dst = -1048576;
        end
        e.nx = nwp_pkg::NRM_W'(nrm[0]);
        e.ny = nwp_pkg::NRM_W'(nrm[1]);
        e.nz = nwp_pkg::NRM_W'(nrm[2]);
        e.cx = nwp_pkg::COORD_W'(ctr[0]);
        e.cy = nwp_pkg::COORD_W'(ctr[1]);
        e.cz = nwp_pkg::COORD_W'(ctr[2]);
        e.pdist = nwp_pkg::DIST_W'(dst);
        e.cnt = seen_count[nwp_pkg::CNT_W-1:0];
        expected_planes.insert(expected_planes.size(), e);
        if (e.ok) valid_planes++;
        if (seen_count == nwp_pkg::MAX_VERTICES) overflow_polys++;
        for (int i = 0; i < 3; i++) begin
            first_v[i] = 0; prev_v[i] = 0; newell_sum[i] = 0; coord_sum[i] = 0;
        end
        seen_count = 0;
    endfunction

    // Sender: bursts and gaps, optional drain before some polygons
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                plane_accept('{i_vertex_x, i_vertex_y, i_vertex_z, i_last_vertex, 1'b0});
                vertices_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_vertices.size() == 0 ||
                             (pending_vertices[0].drain &&
                              (expected_planes.size() != 0 ||
                               (i_valid && !o_stall && i_last_vertex)))) begin
                    i_valid <= 1'b0;
                end else begin
                    if (pending_vertices[0].drain) drains++;
                    i_vertex_x    <= pending_vertices[0].x;
                    i_vertex_y    <= pending_vertices[0].y;
                    i_vertex_z    <= pending_vertices[0].z;
                    i_last_vertex <= pending_vertices[0].last;
                    i_valid       <= 1'b1;
                    void'(pending_vertices.pop_front());
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Receiver: changing stall pattern plus one long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (!hold_done && planes_checked >= 25 && hold_left == 0) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (stall_mode_timer == 0) begin
                stall_mode_timer = $urandom_range(200, 2000);
                stall_mode = $urandom_range(0, 2);
            end
            stall_mode_timer--;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= $urandom_range(0, 1);
                    default: i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                t_plane got, exp_p;
                got = '{o_normal_x, o_normal_y, o_normal_z, o_center_x, o_center_y,
                        o_center_z, o_plane_distance, o_vertex_count, o_plane_valid};
                if (expected_planes.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %p", got);
                end else begin
                    exp_p = expected_planes.pop_front();
                    planes_checked++;
                    if (got.nx !== exp_p.nx || got.ny !== exp_p.ny || got.nz !== exp_p.nz ||
                        got.cx !== exp_p.cx || got.cy !== exp_p.cy || got.cz !== exp_p.cz ||
                        got.pdist !== exp_p.pdist || got.cnt !== exp_p.cnt ||
                        got.ok !== exp_p.ok) begin
                        errors++;
                        mismatches++;
                        if (errors <= 10) begin
                            $display("plane %0d mismatch", planes_checked);
                            $display("  exp %p", exp_p);
                            $display("  got %p", got);
                        end
                    end
                end
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", idle_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic signed [nwp_pkg::COORD_W-1:0] rand_coord(int mode, int base);
        case (mode)
            0: return nwp_pkg::COORD_W'($urandom);
            1: return nwp_pkg::COORD_W'(base + int'($urandom_range(0, 2048)) - 1024);
            default: return nwp_pkg::COORD_W'(int'($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    task automatic add_poly(int n, int mode);
        t_vertex v;
        int bx, by, bz;
        bx = $urandom_range(0, 1000000) - 500000;
        by = $urandom_range(0, 1000000) - 500000;
        bz = $urandom_range(0, 1000000) - 500000;
        for (int i = 0; i < n; i++) begin
            v.x = rand_coord(mode, bx);
            v.y = rand_coord(mode, by);
            v.z = rand_coord(mode, bz);
            v.last = (i == n - 1);
            v.drain = (i == 0) && ($urandom_range(0, 29) == 0);
            pending_vertices.insert(pending_vertices.size(), v);
        end
    endtask

    task automatic add_vertex(int x, int y, int z, bit last);
        t_vertex v;
        v.x = nwp_pkg::COORD_W'(x);
        v.y = nwp_pkg::COORD_W'(y);
        v.z = nwp_pkg::COORD_W'(z);
        v.last = last;
        v.drain = 1'b0;
        pending_vertices.insert(pending_vertices.size(), v);
    endtask

    initial begin
        int total, n, mode, big_left;
        i_rst_n = 1'b0;
        i_valid = 1'b0; i_stall = 1'b0;
        i_vertex_x = '0; i_vertex_y = '0; i_vertex_z = '0; i_last_vertex = 1'b0;
        seen_count = 0;
        for (int i = 0; i < 3; i++) begin
            first_v[i] = 0; prev_v[i] = 0; newell_sum[i] = 0; coord_sum[i] = 0;
        end

        // directed: single vertex, two vertices, extremes, degenerate shapes
        add_vertex(524287, -524288, 524287, 1);
        add_vertex(-524288, -524288, -524288, 0);
        add_vertex(524287, 524287, 524287, 1);
        add_vertex(524287, -524288, 0, 0);
        add_vertex(-524288, 524287, 0, 0);
        add_vertex(0, 0, 524287, 1);
        add_vertex(0, 0, 0, 0);
        add_vertex(256, 256, 256, 0);
        add_vertex(512, 512, 512, 1);              // collinear: zero normal
        add_vertex(-524288, -524288, -524288, 0);
        add_vertex(-524288, -524288, -524288, 0);
        add_vertex(-524288, -524288, -524288, 1);  // coincident points
        add_vertex(0, 0, 0, 0);
        add_vertex(1, 0, 0, 0);
        add_vertex(1, 1, 0, 0);
        add_vertex(0, 1, 0, 1);                    // tiny square
        add_vertex(-524288, -524288, 524287, 0);
        add_vertex(524287, -524288, 524287, 0);
        add_vertex(524287, 524287, -524288, 0);
        add_vertex(-524288, 524287, -524288, 1);   // large skew quad
        total = pending_vertices.size();
        // the tiny square waits until every earlier result is out
        pending_vertices[12].drain = 1'b1;

        // random polygons, one or two of them past the vertex limit
        big_left = 2;
        while (total < 1850) begin
            mode = $urandom_range(0, 2);
            if (big_left > 0 && $urandom_range(0, 150) == 0) begin
                n = $urandom_range(nwp_pkg::MAX_VERTICES + 1, nwp_pkg::MAX_VERTICES + 6);
                big_left--;
            end else if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 2);
            end else begin
                n = $urandom_range(3, 9);
            end
            add_poly(n, mode);
            total += n;
        end
        if (big_left > 0) add_poly(nwp_pkg::MAX_VERTICES + 2, 0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_vertices.size() == 0);
        @(posedge i_clk);
        while (i_valid) @(posedge i_clk);
        while (expected_planes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("polygons checked: %0d (%0d with a valid plane, %0d at the vertex limit)",
                 planes_checked, valid_planes, overflow_polys);
        $display("vertices sent: %0d, drained pauses: %0d, mismatches: %0d",
                 vertices_sent, drains, mismatches);
        if (errors == 0 && expected_planes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
